@@ hdl/prc_pkg.sv @@
// shared types, constants and the outcode, diff and mag functions of the polyline rectangle clipper
package prc_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * COORD_BITS;
	localparam int CNT_BITS   = $clog2(PROD_BITS);
	localparam int MAX_MOVES  = 8;
	localparam int MOVE_BITS  = $clog2(MAX_MOVES + 1);
	localparam int CFG_IDX_BITS = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic [3:0]                   ocode_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_ZERO = '0;

	localparam ocode_t OC_LEFT   = 4'b0001;
	localparam ocode_t OC_RIGHT  = 4'b0010;
	localparam ocode_t OC_TOP    = 4'b0100;
	localparam ocode_t OC_BOTTOM = 4'b1000;
	localparam ocode_t OC_INSIDE = 4'b0000;

	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd3;

	typedef struct packed {
		coord_t left;
		coord_t right;
		coord_t top;
		coord_t bottom;
	} rect_t;

	// request to the interpolation unit: base + trunc(a*b/c)
	typedef struct packed {
		logic   start;
		coord_t base;
		diff_t  a;
		diff_t  b;
		diff_t  c;
	} prc_req_t;

	typedef struct packed {
		logic   done;
		coord_t result;
	} prc_rsp_t;

	function automatic ocode_t outcode(coord_t x, coord_t y, rect_t r);
		ocode_t c;
		c = OC_INSIDE;
		if (x < r.left)   c = c | OC_LEFT;
		if (x > r.right)  c = c | OC_RIGHT;
		if (y < r.top)    c = c | OC_TOP;
		if (y > r.bottom) c = c | OC_BOTTOM;
		return c;
	endfunction

	function automatic diff_t diff(coord_t p, coord_t q);
		return {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
	endfunction

	function automatic logic [COORD_BITS-1:0] mag(diff_t v);
		diff_t m;
		m = v[DIFF_BITS-1] ? -v : v;
		return m[COORD_BITS-1:0];
	endfunction

endpackage

@@ hdl/prc_interp.sv @@
// shared interpolation unit: one multiply, then restoring division one bit per cycle
module prc_interp (
	input  logic               clk,
	input  logic               arst_n,
	input  prc_pkg::prc_req_t  req,
	output prc_pkg::prc_rsp_t  rsp
);

	typedef enum logic [4:0] {
		U_IDLE = 5'b00001,
		U_MUL  = 5'b00010,
		U_DIV  = 5'b00100,
		U_FIX  = 5'b01000,
		U_DONE = 5'b10000
	} ustate_t;

	ustate_t state_q;
	logic [prc_pkg::CNT_BITS-1:0]   cnt_q;
	logic [prc_pkg::COORD_BITS-1:0] ua_q, ub_q, uc_q;
	logic                           neg_q;
	prc_pkg::coord_t                base_q;
	prc_pkg::coord_t                res_q;
	logic [prc_pkg::PROD_BITS-1:0]  dvd_q;
	logic [prc_pkg::COORD_BITS-1:0] rem_q;

	logic [prc_pkg::COORD_BITS:0]   shifted;
	logic [prc_pkg::COORD_BITS:0]   trial;
	logic                           ge;
	logic [prc_pkg::DIFF_BITS-1:0]  sum;

	assign shifted = {rem_q, dvd_q[prc_pkg::PROD_BITS-1]};
	assign ge      = shifted >= {1'b0, uc_q};
	assign trial   = shifted - {1'b0, uc_q};
	// quotient never exceeds |a|, so its low bits carry it all
	assign sum = neg_q
		? {base_q[prc_pkg::COORD_BITS-1], base_q} - {1'b0, dvd_q[prc_pkg::COORD_BITS-1:0]}
		: {base_q[prc_pkg::COORD_BITS-1], base_q} + {1'b0, dvd_q[prc_pkg::COORD_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				U_IDLE: begin
					if (req.start) state_q <= U_MUL;
				end
				U_MUL: begin
					cnt_q   <= prc_pkg::CNT_BITS'(prc_pkg::PROD_BITS - 1);
					state_q <= U_DIV;
				end
				U_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= U_FIX;
				end
				U_FIX:   state_q <= U_DONE;
				U_DONE:  state_q <= U_IDLE;
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					ua_q   <= prc_pkg::mag(req.a);
					ub_q   <= prc_pkg::mag(req.b);
					uc_q   <= prc_pkg::mag(req.c);
					neg_q  <= req.a[prc_pkg::DIFF_BITS-1] ^ req.b[prc_pkg::DIFF_BITS-1]
						^ req.c[prc_pkg::DIFF_BITS-1];
					base_q <= req.base;
				end
			end
			U_MUL: begin
				dvd_q <= ua_q * ub_q;
				rem_q <= '0;
			end
			U_DIV: begin
				rem_q <= ge ? trial[prc_pkg::COORD_BITS-1:0] : shifted[prc_pkg::COORD_BITS-1:0];
				dvd_q <= {dvd_q[prc_pkg::PROD_BITS-2:0], ge};
			end
			U_FIX: begin
				res_q <= sum[prc_pkg::COORD_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

	assign rsp = {(state_q == U_DONE), res_q};

endmodule

@@ hdl/polyline_rect_clipper_core.sv @@
// polyline rectangle clipper top level: vertex intake, clip sequencer and result register
//
// vertices enter on the input channel (in_valid / in_stall, fields pt_x, pt_y,
// starts_line); each vertex that continues a polyline forms a segment from the
// previous vertex, which is clipped against the rectangle in the four registers
// written through cfg_we / cfg_index / cfg_data (left, right, top, bottom).
// accepted segments leave on the output channel (out_valid / out_stall,
// seg_x1..seg_y2); dropped segments and polyline starts give no transaction.
// each segment is coded against the rectangle and, when accepted, passes the finish
// state that loads the output register; every clip move goes through the one
// shared multiply-divide unit and its bit-serial division. a segment needs 0 to
// 4 moves; at the bound of 8 moves a segment not yet accepted is dropped.
// in_stall stays high while a segment is in work.
// the result sits in an output register, so the next vertex is taken while it
// waits; if the receiver still stalls when the next segment finishes, the
// sequencer holds until the register frees.
// reset clears the previous vertex, sets the rectangle to left = top = 0 and
// right = bottom = largest coordinate, and empties the output register.
module polyline_rect_clipper_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [prc_pkg::COORD_BITS-1:0] pt_x,
	input  logic signed [prc_pkg::COORD_BITS-1:0] pt_y,
	input  logic                              starts_line,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [prc_pkg::COORD_BITS-1:0] seg_x1,
	output logic signed [prc_pkg::COORD_BITS-1:0] seg_y1,
	output logic signed [prc_pkg::COORD_BITS-1:0] seg_x2,
	output logic signed [prc_pkg::COORD_BITS-1:0] seg_y2,
	input  logic                              cfg_we,
	input  logic [prc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [prc_pkg::COORD_BITS-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_CODE   = 4'b0010,
		S_WAIT   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t                        state_q;
	prc_pkg::rect_t                rect_q;
	prc_pkg::coord_t               prev_x_q, prev_y_q;
	logic                          have_prev_q;
	prc_pkg::coord_t               x1_q, y1_q, x2_q, y2_q;
	logic [prc_pkg::MOVE_BITS-1:0] moves_q;
	logic                          side1_q;
	logic                          xfix_q;
	prc_pkg::coord_t               edge_q;
	logic                          out_valid_q;
	prc_pkg::coord_t               ox1_q, oy1_q, ox2_q, oy2_q;

	prc_pkg::ocode_t   oc1, oc2, sel;
	logic              reject, accept, runaway;
	logic              xfix;
	prc_pkg::coord_t   edge_val;
	prc_pkg::prc_req_t req;
	prc_pkg::prc_rsp_t rsp;
	logic              in_take;
	logic              out_free;

	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign oc1     = prc_pkg::outcode(x1_q, y1_q, rect_q);
	assign oc2     = prc_pkg::outcode(x2_q, y2_q, rect_q);
	assign sel     = (oc1 != prc_pkg::OC_INSIDE) ? oc1 : oc2;
	assign reject  = (oc1 & oc2) != prc_pkg::OC_INSIDE;
	assign accept  = (oc1 == prc_pkg::OC_INSIDE) && (oc2 == prc_pkg::OC_INSIDE);
	assign runaway = moves_q >= prc_pkg::MOVE_BITS'(prc_pkg::MAX_MOVES);

	// edge pick follows the lowest set outcode bit
	always_comb begin
		req.start = (state_q == S_CODE) && !reject && !accept && !runaway;
		if ((sel & prc_pkg::OC_LEFT) != prc_pkg::OC_INSIDE) begin
			xfix     = 1'b1;
			edge_val = rect_q.left;
		end else if ((sel & prc_pkg::OC_RIGHT) != prc_pkg::OC_INSIDE) begin
			xfix     = 1'b1;
			edge_val = rect_q.right;
		end else if ((sel & prc_pkg::OC_TOP) != prc_pkg::OC_INSIDE) begin
			xfix     = 1'b0;
			edge_val = rect_q.top;
		end else begin
			xfix     = 1'b0;
			edge_val = rect_q.bottom;
		end
		if (xfix) begin
			req.base = y1_q;
			req.a    = prc_pkg::diff(y2_q, y1_q);
			req.b    = prc_pkg::diff(edge_val, x1_q);
			req.c    = prc_pkg::diff(x2_q, x1_q);
		end else begin
			req.base = x1_q;
			req.a    = prc_pkg::diff(x2_q, x1_q);
			req.b    = prc_pkg::diff(edge_val, y1_q);
			req.c    = prc_pkg::diff(y2_q, y1_q);
		end
	end

	prc_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q.left   <= prc_pkg::COORD_ZERO;
			rect_q.right  <= prc_pkg::COORD_MAX;
			rect_q.top    <= prc_pkg::COORD_ZERO;
			rect_q.bottom <= prc_pkg::COORD_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				prc_pkg::REG_LEFT:   rect_q.left   <= cfg_data;
				prc_pkg::REG_RIGHT:  rect_q.right  <= cfg_data;
				prc_pkg::REG_TOP:    rect_q.top    <= cfg_data;
				prc_pkg::REG_BOTTOM: rect_q.bottom <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			have_prev_q <= 1'b0;
			prev_x_q    <= prc_pkg::COORD_ZERO;
			prev_y_q    <= prc_pkg::COORD_ZERO;
			moves_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						prev_x_q    <= pt_x;
						prev_y_q    <= pt_y;
						have_prev_q <= 1'b1;
						moves_q     <= '0;
						if (have_prev_q && !starts_line) state_q <= S_CODE;
					end
				end
				S_CODE: begin
					if (reject || (!accept && runaway)) state_q <= S_IDLE;
					else if (accept) state_q <= S_FINISH;
					else state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.done) begin
						moves_q <= moves_q + 1'b1;
						state_q <= S_CODE;
					end
				end
				S_FINISH: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// endpoint and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_take) begin
			x1_q <= prev_x_q;
			y1_q <= prev_y_q;
			x2_q <= pt_x;
			y2_q <= pt_y;
		end
		if (req.start) begin
			side1_q <= (oc1 != prc_pkg::OC_INSIDE);
			xfix_q  <= xfix;
			edge_q  <= edge_val;
		end
		if (state_q == S_WAIT && rsp.done) begin
			if (side1_q) begin
				x1_q <= xfix_q ? edge_q : rsp.result;
				y1_q <= xfix_q ? rsp.result : edge_q;
			end else begin
				x2_q <= xfix_q ? edge_q : rsp.result;
				y2_q <= xfix_q ? rsp.result : edge_q;
			end
		end
		if (state_q == S_FINISH && out_free) begin
			ox1_q <= x1_q;
			oy1_q <= y1_q;
			ox2_q <= x2_q;
			oy2_q <= y2_q;
		end
	end

	assign out_valid = out_valid_q;
	assign seg_x1    = ox1_q;
	assign seg_y1    = oy1_q;
	assign seg_x2    = ox2_q;
	assign seg_y2    = oy2_q;

	// the shared unit answers only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_WAIT)
		else $error("interp done outside wait");

	a_moves_bound: assert property (@(posedge clk) disable iff (!arst_n)
		moves_q <= prc_pkg::MOVE_BITS'(prc_pkg::MAX_MOVES))
		else $error("clip move count beyond bound");

	a_finish_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH |-> oc1 == prc_pkg::OC_INSIDE && oc2 == prc_pkg::OC_INSIDE)
		else $error("finishing segment not inside rectangle");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("output transaction without finished segment");

	a_start_from_code: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> state_q == S_WAIT)
		else $error("interp request not followed by wait");

endmodule

@@ test/prc_segment_checker.sv @@
// checker of the polyline rectangle clipper: predicts the clipped segments and compares them
module prc_segment_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  prc_pkg::coord_t                  pt_x,
	input  prc_pkg::coord_t                  pt_y,
	input  logic                             starts_line,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  prc_pkg::coord_t                  seg_x1,
	input  prc_pkg::coord_t                  seg_y1,
	input  prc_pkg::coord_t                  seg_x2,
	input  prc_pkg::coord_t                  seg_y2,
	input  logic                             cfg_we,
	input  logic [prc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [prc_pkg::COORD_BITS-1:0]   cfg_data,
	output int                               mismatches,
	output int                               seg_pending,
	output int                               vertex_count,
	output int                               seg_count
);

	typedef struct packed {
		prc_pkg::coord_t x1;
		prc_pkg::coord_t y1;
		prc_pkg::coord_t x2;
		prc_pkg::coord_t y2;
	} clip_seg_t;

	clip_seg_t clip_seg_q[$];
	clip_seg_t seg_want, seg_got;

	// window and previous vertex, kept wide so that no step can wrap
	longint win_l, win_r, win_t, win_b;
	longint last_x, last_y;
	bit     last_valid;

	function automatic prc_pkg::ocode_t region(longint x, longint y);
		prc_pkg::ocode_t c;
		c = prc_pkg::OC_INSIDE;
		if (x < win_l) c = c | prc_pkg::OC_LEFT;
		if (x > win_r) c = c | prc_pkg::OC_RIGHT;
		if (y < win_t) c = c | prc_pkg::OC_TOP;
		if (y > win_b) c = c | prc_pkg::OC_BOTTOM;
		return c;
	endfunction

	// base + a*b/c, quotient truncated toward zero
	function automatic longint slide(longint base, longint a, longint b, longint c);
		if (c == 0) return base;
		return base + (a * b) / c;
	endfunction

	function automatic bit clip_against_rect(longint x1, longint y1, longint x2, longint y2,
			output clip_seg_t seg);
		prc_pkg::ocode_t c1, c2, c;
		longint nx, ny;
		bit     decided, keep;
		int     moves;
		c1 = region(x1, y1);
		c2 = region(x2, y2);
		decided = 1'b0;
		keep = 1'b0;
		nx = 0;
		ny = 0;
		for (moves = 0; moves <= prc_pkg::MAX_MOVES && !decided; moves++) begin
			if ((c1 & c2) != prc_pkg::OC_INSIDE) begin
				decided = 1'b1;
			end else if (c1 == prc_pkg::OC_INSIDE && c2 == prc_pkg::OC_INSIDE) begin
				decided = 1'b1;
				keep = 1'b1;
			end else if (moves == prc_pkg::MAX_MOVES) begin
				// safety bound on clip moves: give up and drop
				decided = 1'b1;
			end else begin
				c = (c1 != prc_pkg::OC_INSIDE) ? c1 : c2;
				if ((c & prc_pkg::OC_LEFT) != prc_pkg::OC_INSIDE) begin
					nx = win_l;
					ny = slide(y1, y2 - y1, win_l - x1, x2 - x1);
				end else if ((c & prc_pkg::OC_RIGHT) != prc_pkg::OC_INSIDE) begin
					nx = win_r;
					ny = slide(y1, y2 - y1, win_r - x1, x2 - x1);
				end else if ((c & prc_pkg::OC_TOP) != prc_pkg::OC_INSIDE) begin
					ny = win_t;
					nx = slide(x1, x2 - x1, win_t - y1, y2 - y1);
				end else begin
					ny = win_b;
					nx = slide(x1, x2 - x1, win_b - y1, y2 - y1);
				end
				if (c1 != prc_pkg::OC_INSIDE) begin
					x1 = nx;
					y1 = ny;
					c1 = region(nx, ny);
				end else begin
					x2 = nx;
					y2 = ny;
					c2 = region(nx, ny);
				end
			end
		end
		seg.x1 = prc_pkg::coord_t'(x1);
		seg.y1 = prc_pkg::coord_t'(y1);
		seg.x2 = prc_pkg::coord_t'(x2);
		seg.y2 = prc_pkg::coord_t'(y2);
		return keep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l = 0;
			win_r = longint'(prc_pkg::COORD_MAX);
			win_t = 0;
			win_b = longint'(prc_pkg::COORD_MAX);
			last_x = 0;
			last_y = 0;
			last_valid = 1'b0;
			clip_seg_q.delete();
			mismatches = 0;
			seg_pending = 0;
			vertex_count = 0;
			seg_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seg_count++;
				seg_got = '{seg_x1, seg_y1, seg_x2, seg_y2};
				if (clip_seg_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected segment (%0d,%0d)-(%0d,%0d)",
							seg_got.x1, seg_got.y1, seg_got.x2, seg_got.y2);
					mismatches++;
				end else begin
					seg_want = clip_seg_q.pop_front();
					if (seg_want != seg_got) begin
						if (mismatches < 10)
							$display({"segment mismatch: expected (%0d,%0d)-(%0d,%0d)",
								" got (%0d,%0d)-(%0d,%0d)"},
								seg_want.x1, seg_want.y1, seg_want.x2, seg_want.y2,
								seg_got.x1, seg_got.y1, seg_got.x2, seg_got.y2);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					prc_pkg::REG_LEFT:   win_l = longint'(prc_pkg::coord_t'(cfg_data));
					prc_pkg::REG_RIGHT:  win_r = longint'(prc_pkg::coord_t'(cfg_data));
					prc_pkg::REG_TOP:    win_t = longint'(prc_pkg::coord_t'(cfg_data));
					prc_pkg::REG_BOTTOM: win_b = longint'(prc_pkg::coord_t'(cfg_data));
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				vertex_count++;
				// no previous vertex counts as a polyline start
				if (last_valid && !starts_line) begin
					if (clip_against_rect(last_x, last_y, longint'(pt_x), longint'(pt_y),
							seg_want))
						clip_seg_q.push_back(seg_want);
				end
				last_x = longint'(pt_x);
				last_y = longint'(pt_y);
				last_valid = 1'b1;
			end
			seg_pending = clip_seg_q.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// top of the polyline rectangle clipper test: clock, reset, stimulus, receiver stalls, verdict
module testbench;

	localparam int HALF_PERIOD   = 2;
	localparam int SETTLE_CYCLES = 400;
	localparam int IDLE_LIMIT    = 20000;
	localparam int HOLD_CYCLES   = 3000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 175;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	prc_pkg::coord_t                  pt_x = '0;
	prc_pkg::coord_t                  pt_y = '0;
	logic                             starts_line = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	prc_pkg::coord_t                  seg_x1, seg_y1, seg_x2, seg_y2;
	logic                             cfg_we = 1'b0;
	logic [prc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [prc_pkg::COORD_BITS-1:0]   cfg_data = '0;

	int mismatches, seg_pending, vertex_count, seg_count;

	longint   cur_l, cur_r, cur_t, cur_b;
	int       items_sent = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	int       stall_run = 0;
	rx_mode_t stall_mode = RX_FREE;
	logic     rx_hold = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	polyline_rect_clipper_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pt_x        (pt_x),
		.pt_y        (pt_y),
		.starts_line (starts_line),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.seg_x1      (seg_x1),
		.seg_y1      (seg_y1),
		.seg_x2      (seg_x2),
		.seg_y2      (seg_y2),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	prc_segment_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pt_x         (pt_x),
		.pt_y         (pt_y),
		.starts_line  (starts_line),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.seg_x1       (seg_x1),
		.seg_y1       (seg_y1),
		.seg_x2       (seg_x2),
		.seg_y2       (seg_y2),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.seg_pending  (seg_pending),
		.vertex_count (vertex_count),
		.seg_count    (seg_count)
	);

	// receiver: changing stall pattern, or a long hold-off when asked
	always @(posedge clk) begin
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else begin
			if (stall_run == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				stall_run = $urandom_range(20, 400);
			end
			stall_run--;
			case (stall_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:  out_stall <= ~out_stall;
			endcase
		end
	end

	// long hold-off while the sender keeps offering vertices
	initial begin
		wait (items_sent >= 600);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d segments outstanding",
				idle_cycles, seg_pending);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic offer_vertex(input int x, input int y, input logic s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pt_x <= prc_pkg::coord_t'(x);
		pt_y <= prc_pkg::coord_t'(y);
		starts_line <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain_segments();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (seg_pending == 0);
	endtask

	// dropped segments leave no trace, so wait out the worst case before writing
	task automatic set_rect(input longint l, input longint r, input longint t, input longint b);
		drain_segments();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= prc_pkg::REG_LEFT;
		cfg_data <= l[prc_pkg::COORD_BITS-1:0];
		@(posedge clk);
		cfg_index <= prc_pkg::REG_RIGHT;
		cfg_data <= r[prc_pkg::COORD_BITS-1:0];
		@(posedge clk);
		cfg_index <= prc_pkg::REG_TOP;
		cfg_data <= t[prc_pkg::COORD_BITS-1:0];
		@(posedge clk);
		cfg_index <= prc_pkg::REG_BOTTOM;
		cfg_data <= b[prc_pkg::COORD_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_l = l;
		cur_r = r;
		cur_t = t;
		cur_b = b;
	endtask

	// mostly near the window, some anywhere, some at the extremes
	function automatic int pick_coord(longint lo, longint hi);
		longint a, b, m, v;
		int     sel;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		m = (b - a) / 4 + 8;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			v = a - m + longint'($urandom_range(0, b - a + 2 * m));
		end else if (sel < 8) begin
			return int'(prc_pkg::coord_t'($urandom));
		end else begin
			case ($urandom_range(0, 5))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				3: v = -1;
				4: v = a;
				default: v = b;
			endcase
		end
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		return int'(v);
	endfunction

	function automatic void rand_span(output longint lo, output longint hi);
		lo = longint'($urandom_range(0, 50000)) - 25000;
		hi = lo + longint'($urandom_range(0, 12000));
		if (hi > 32767) hi = 32767;
	endfunction

	initial begin
		longint l, r, t, b;
		int     ph, k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_l = 0;
		cur_r = 32767;
		cur_t = 0;
		cur_b = 32767;

		// reset window; first vertex has no predecessor
		offer_vertex(100, 100, 1'b0);
		offer_vertex(200, 300, 1'b0);
		offer_vertex(-32768, -32768, 1'b0);
		offer_vertex(32767, 32767, 1'b0);
		offer_vertex(-32768, 32767, 1'b1);
		offer_vertex(32767, -32768, 1'b0);
		offer_vertex(0, 0, 1'b0);
		offer_vertex(-1, -1, 1'b0);
		offer_vertex(-5, -7, 1'b0);
		offer_vertex(0, 32767, 1'b0);
		offer_vertex(32767, 0, 1'b0);
		offer_vertex(16000, -20, 1'b1);

		// small window: clipping on the left, right, top and bottom edges
		set_rect(-100, 100, -50, 50);
		offer_vertex(-200, 0, 1'b1);
		offer_vertex(200, 0, 1'b0);
		offer_vertex(0, -300, 1'b0);
		offer_vertex(0, 300, 1'b0);
		offer_vertex(150, 60, 1'b0);
		offer_vertex(-150, -60, 1'b0);
		offer_vertex(100, 50, 1'b0);
		offer_vertex(101, 51, 1'b0);
		offer_vertex(-32768, 32767, 1'b0);
		offer_vertex(32767, -32768, 1'b0);
		offer_vertex(30, 40, 1'b0);
		offer_vertex(-32768, -32768, 1'b1);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					l = -32768; r = 32767; t = -32768; b = 32767;
				end
				1: begin
					l = -longint'($urandom_range(1, 300)); r = $urandom_range(1, 300);
					t = -longint'($urandom_range(1, 300)); b = $urandom_range(1, 300);
				end
				2: begin
					// inverted in x
					rand_span(r, l);
					rand_span(t, b);
				end
				3: begin
					// single point window
					l = longint'($urandom_range(0, 2000)) - 1000; r = l;
					t = longint'($urandom_range(0, 2000)) - 1000; b = t;
				end
				4: begin
					l = -32768; r = -32768 + longint'($urandom_range(0, 3000));
					t = 32767 - longint'($urandom_range(0, 3000)); b = 32767;
				end
				6: begin
					// inverted in y
					rand_span(l, r);
					rand_span(b, t);
				end
				default: begin
					rand_span(l, r);
					rand_span(t, b);
				end
			endcase
			set_rect(l, r, t, b);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 5 && k == PHASE_ITEMS / 2)
					drain_segments();
				offer_vertex(pick_coord(cur_l, cur_r), pick_coord(cur_t, cur_b),
					$urandom_range(0, 11) == 0);
			end
		end

		drain_segments();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d vertices and %0d clipped segments over %0d window settings,",
			vertex_count, seg_count, RANDOM_PHASES + 2);
		$display("including inverted and single point windows, a long receiver hold-off and a drain");
		if (mismatches == 0 && seg_pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
